/* rtl/core/positional_circular_list_defines.svh */
// ----------------------------------------------------------------------------
// positional_circular_list_defines
// Assertion macros shared by the list checker.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_CIRCULAR_LIST_DEFINES_SVH
`define POSITIONAL_CIRCULAR_LIST_DEFINES_SVH

// same-cycle implication
`define PCL_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional_circular_list: same-cycle check failed");

// next-cycle implication
`define PCL_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional_circular_list: next-cycle check failed");

`endif

/* rtl/core/pcl_pkg.sv */
// ----------------------------------------------------------------------------
// pcl_pkg
// Types and constants of the positional circular list.
// ----------------------------------------------------------------------------
package pcl_pkg;

  localparam int DATA_W = 32;
  localparam int REQ_W  = 3;
  localparam int POS_W  = 8;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND    = 3'd0,
    REQ_INSERT    = 3'd1,
    REQ_DEL_FIRST = 3'd2,
    REQ_DEL_AFTER = 3'd3,
    REQ_DISPLAY   = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SMALL = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SHOW = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    COP_HOLD = 2'd0,
    COP_INS  = 2'd1,
    COP_DEL  = 2'd2,
    COP_ROT  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [CNT_W-1:0]         idx;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

/* rtl/core/positional_circular_list.sv */
// ----------------------------------------------------------------------------
// positional_circular_list
// Ordered circular list of signed words held in a chain of entry cells.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Append, insert,
// delete-first, delete-after and unknown codes finish with a single result
// (out_last high) that shows on the out_ ports for one cycle, marked by
// out_strobe, the cycle after the request is taken, and busy stays low so
// a new request may follow at once.
// Display of a list with N entries rotates the cell chain once around: one
// beat per cycle, with out_last on the final beat; the first beat passes
// through the S_SHOW state and the output registers after acceptance. busy
// is high while the chain rotates, and the next request waits until it ends.
// Inserts and deletes shift the cells from the target index on by one place.
// Synchronous reset empties the list; entry contents are not cleared.
// The receiver has no stall: each beat is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module positional_circular_list #(
  parameter int CAPACITY = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [pcl_pkg::REQ_W-1:0]          in_req_type,
  input  logic signed [pcl_pkg::DATA_W-1:0]  in_value,
  input  logic [pcl_pkg::POS_W-1:0]          in_position,
  output logic                               out_strobe,
  output logic [pcl_pkg::STAT_W-1:0]         out_status,
  output logic signed [pcl_pkg::DATA_W-1:0]  out_data,
  output logic [pcl_pkg::CNT_W-1:0]          out_slot,
  output logic                               out_last
);
  import pcl_pkg::*;

  localparam int               IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] show_r, show_nxt;

  logic                     strobe_r, strobe_nxt;
  status_t                  status_r, status_nxt;
  logic signed [DATA_W-1:0] data_r, data_nxt;
  logic [CNT_W-1:0]         slot_r, slot_nxt;
  logic                     last_r, last_nxt;

  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] cell_q [CAPACITY];

  logic             accept;
  logic [POS_W-1:0] pos_m1, del_p, cnt_w;
  logic [CNT_W-1:0] ins_idx, del_idx;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign pos_m1 = in_position - POS_W'(1);
  assign cnt_w  = POS_W'(count_r);
  assign del_p  = (in_position == '0) ? '0 : pos_m1;

  always_comb begin
    if (in_position <= POS_W'(1) || count_r == '0) begin
      ins_idx = '0;
    end else if (pos_m1 > cnt_w) begin
      ins_idx = count_r;
    end else begin
      ins_idx = pos_m1[CNT_W-1:0];
    end
    if (del_p >= cnt_w - POS_W'(1)) begin
      del_idx = '0;
    end else begin
      del_idx = del_p[CNT_W-1:0] + CNT_W'(1);
    end
  end

  always_comb begin
    cmd        = '{op: COP_HOLD, idx: '0, count: count_r, value: in_value};
    state_nxt  = state_r;
    count_nxt  = count_r;
    show_nxt   = show_r;
    strobe_nxt = 1'b0;
    status_nxt = ST_OK;
    data_nxt   = '0;
    slot_nxt   = '0;
    last_nxt   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          strobe_nxt = 1'b1;
          unique case (in_req_type)
            REQ_APPEND: begin
              if (count_r >= CAP_C) begin
                status_nxt = ST_FULL;
              end else begin
                cmd.op    = COP_INS;
                cmd.idx   = count_r;
                slot_nxt  = count_r + CNT_W'(1);
                count_nxt = count_r + CNT_W'(1);
              end
            end
            REQ_INSERT: begin
              if (count_r >= CAP_C) begin
                status_nxt = ST_FULL;
              end else begin
                cmd.op    = COP_INS;
                cmd.idx   = ins_idx;
                slot_nxt  = ins_idx + CNT_W'(1);
                count_nxt = count_r + CNT_W'(1);
              end
            end
            REQ_DEL_FIRST: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                cmd.op    = COP_DEL;
                cmd.idx   = '0;
                data_nxt  = cell_q[0];
                slot_nxt  = CNT_W'(1);
                count_nxt = count_r - CNT_W'(1);
              end
            end
            REQ_DEL_AFTER: begin
              if (count_r < CNT_W'(2)) begin
                status_nxt = ST_SMALL;
              end else begin
                cmd.op    = COP_DEL;
                cmd.idx   = del_idx;
                data_nxt  = cell_q[del_idx[IW-1:0]];
                slot_nxt  = del_idx + CNT_W'(1);
                count_nxt = count_r - CNT_W'(1);
              end
            end
            REQ_DISPLAY: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                strobe_nxt = 1'b0;
                show_nxt   = '0;
                state_nxt  = S_SHOW;
              end
            end
            default: status_nxt = ST_OK;
          endcase
        end
      end
      S_SHOW: begin
        cmd.op     = COP_ROT;
        strobe_nxt = 1'b1;
        data_nxt   = cell_q[0];
        slot_nxt   = show_r + CNT_W'(1);
        last_nxt   = (show_r + CNT_W'(1) == count_r);
        show_nxt   = show_r + CNT_W'(1);
        if (show_r + CNT_W'(1) == count_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      show_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      show_r   <= show_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    data_r   <= data_nxt;
    slot_r   <= slot_nxt;
    last_r   <= last_nxt;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = in_value;
    end else begin : g_mid_l
      assign left_w = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = cell_q[0];
    end else begin : g_mid_r
      assign right_w = cell_q[g+1];
    end
    pcl_cell #(
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .head_i  (cell_q[0]),
      .data_o  (cell_q[g])
    );
  end

  assign out_strobe = strobe_r;
  assign out_status = status_r;
  assign out_data   = data_r;
  assign out_slot   = slot_r;
  assign out_last   = last_r;

endmodule

/* rtl/core/pcl_cell.sv */
// ----------------------------------------------------------------------------
// pcl_cell
// One list entry; loads, shifts from a neighbor or rotates per the command.
// ----------------------------------------------------------------------------
module pcl_cell #(
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  pcl_pkg::cell_cmd_t                 cmd_i,
  input  logic signed [pcl_pkg::DATA_W-1:0]  left_i,
  input  logic signed [pcl_pkg::DATA_W-1:0]  right_i,
  input  logic signed [pcl_pkg::DATA_W-1:0]  head_i,
  output logic signed [pcl_pkg::DATA_W-1:0]  data_o
);
  import pcl_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] MY_NXT = CNT_W'(IDX + 1);

  logic signed [DATA_W-1:0] data_r, data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (cmd_i.op)
      COP_INS: begin
        if (MY_IDX > cmd_i.idx) begin
          data_nxt = left_i;
        end else if (MY_IDX == cmd_i.idx) begin
          data_nxt = cmd_i.value;
        end
      end
      COP_DEL: begin
        if (MY_IDX >= cmd_i.idx && MY_NXT < cmd_i.count) begin
          data_nxt = right_i;
        end
      end
      COP_ROT: begin
        if (MY_NXT == cmd_i.count) begin
          data_nxt = head_i;
        end else if (MY_NXT < cmd_i.count) begin
          data_nxt = right_i;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

/* rtl/core/pcl_checker.sv */
// ----------------------------------------------------------------------------
// pcl_checker
// Port-level checks of the positional circular list, bound to the top.
// ----------------------------------------------------------------------------
`include "positional_circular_list_defines.svh"

module pcl_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [pcl_pkg::REQ_W-1:0]  in_req_type,
  input logic                       out_strobe,
  input logic [pcl_pkg::STAT_W-1:0] out_status,
  input logic [pcl_pkg::CNT_W-1:0]  out_slot,
  input logic                       out_last
);
  import pcl_pkg::*;

  // a failed request touches no slot and ends the request
  `PCL_ASSERT_IMP(a_err_beat, out_strobe && out_status != ST_OK, out_last && out_slot == '0)

  // every request except display answers in the next cycle with one beat
  `PCL_ASSERT_NXT(a_single_beat, start && !busy && in_req_type != REQ_DISPLAY, out_strobe && out_last)

  // display beats come back to back until the last one
  `PCL_ASSERT_NXT(a_show_run, out_strobe && !out_last, out_strobe)

  // no request is taken while a display is still running
  `PCL_ASSERT_IMP(a_show_busy, out_strobe && !out_last, busy)

endmodule

bind positional_circular_list pcl_checker u_pcl_checker (.*);
